// ===== design/rgbablit_pkg.sv =====
// Shared package for the RGBA4444 blit pixel engine.
// Holds sizes, register and mode codes, FSM state, control structs and the divide-by-15 helper.
package rgbablit_pkg;

   localparam int COORD_W   = 13;
   localparam int ADDR_W    = 32;
   localparam int PIX_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   localparam logic [COORD_W-1:0] MAX_WIDTH = COORD_W'(4096);
   localparam logic [COORD_W-1:0] MAX_ROWS  = COORD_W'(4096);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE        = 3'd0,
      REG_BLEND_ALPHA = 3'd1,
      REG_FILL_COLOR  = 3'd2,
      REG_DST_BASE    = 3'd3,
      REG_DST_STRIDE  = 3'd4,
      REG_WIDTH       = 3'd5,
      REG_ROW_TOTAL   = 3'd6
   } reg_index_type;

   localparam logic [1:0] MODE_FILL  = 2'd0;
   localparam logic [1:0] MODE_COPY  = 2'd1;
   localparam int         MODE_BLEND_BIT = 1;

   localparam logic [3:0] NIBBLE_MAX = 4'hf;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_MIX,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic load;
      logic scale;
      logic mix;
   } cmd_type;

   typedef struct packed {
      logic width_zero;
   } status_type;

   // exact floor(x / 15) for x up to 225
   function automatic logic [3:0] div15(input logic [7:0] x);
      logic [13:0] p;
      p = 14'({1'b0, x} + 9'd1) * 14'd17;
      return p[11:8];
   endfunction

endpackage

// ===== design/rgbablit_ctrl.sv =====
// Controller for the RGBA4444 blit pixel engine.
// Sequences load, scale, mix and send for one item; uses rgbablit_pkg.
module rgbablit_ctrl
   import rgbablit_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // drop items while the row width is zero
            if (req_valid && !status.width_zero) begin
               cmd.load = 1'b1;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/rgbablit_dpath.sv =====
// Datapath for the RGBA4444 blit pixel engine: control registers, rectangle walk,
// address generation and the fill/copy/blend pixel unit. Uses rgbablit_pkg.
module rgbablit_dpath
   import rgbablit_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   input  logic [PIX_W-1:0]     req_src_pixel,
   input  logic [PIX_W-1:0]     req_dst_pixel,
   output logic [ADDR_W-1:0]    rsp_write_address,
   output logic [PIX_W-1:0]     rsp_out_pixel,
   output logic                 rsp_last_pixel
);

   logic [1:0]         mode_ff;
   logic [3:0]         alpha_ff;
   logic [PIX_W-1:0]   fill_ff;
   logic [ADDR_W-1:0]  base_ff;
   logic [15:0]        stride_ff;
   logic [COORD_W-1:0] width_ff;
   logic [COORD_W-1:0] rows_ff;

   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [ADDR_W-1:0]  rs_ff, rs_in;

   logic [PIX_W-1:0]   src_ff, dst_ff;
   logic [3:0]         sc_ff;
   logic [PIX_W-1:0]   pix_ff, pix_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               last_ff, last_in;

   logic [COORD_W-1:0] w_eff, h_eff, col_cur, row_cur;
   logic [ADDR_W-1:0]  rs_cur, stride_ext;
   logic               row_end;
   logic [7:0]         scale_prod;
   logic [7:0]         mix_sum [4];
   logic [3:0]         sn [4];
   logic [3:0]         dn [4];
   logic [3:0]         sc_inv;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_FILL;
         alpha_ff  <= '0;
         fill_ff   <= '0;
         base_ff   <= '0;
         stride_ff <= '0;
         width_ff  <= '0;
         rows_ff   <= COORD_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            REG_MODE:        mode_ff   <= csr_data[1:0];
            REG_BLEND_ALPHA: alpha_ff  <= csr_data[3:0];
            REG_FILL_COLOR:  fill_ff   <= csr_data[PIX_W-1:0];
            REG_DST_BASE:    base_ff   <= csr_data[ADDR_W-1:0];
            REG_DST_STRIDE:  stride_ff <= csr_data[15:0];
            REG_WIDTH:       width_ff  <= csr_data[COORD_W-1:0];
            REG_ROW_TOTAL:   rows_ff   <= csr_data[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign status.width_zero = (width_ff == '0);

   always_comb begin
      w_eff = (width_ff > MAX_WIDTH) ? MAX_WIDTH : width_ff;
      h_eff = (rows_ff == '0) ? COORD_W'(1) : rows_ff;
      if (h_eff > MAX_ROWS) begin
         h_eff = MAX_ROWS;
      end
      col_cur = col_ff;
      row_cur = row_ff;
      // restart the walk if the rectangle shrank below the position
      if (col_ff >= w_eff || row_ff >= h_eff) begin
         col_cur = '0;
         row_cur = '0;
      end
      rs_cur     = (col_cur == '0 && row_cur == '0) ? base_ff : rs_ff;
      stride_ext = {{(ADDR_W-16){stride_ff[15]}}, stride_ff};
      row_end    = (col_cur == w_eff - COORD_W'(1));
      last_in    = row_end && (row_cur == h_eff - COORD_W'(1));
      addr_in    = rs_cur + ADDR_W'({col_cur, 1'b0});
      col_in     = col_cur + COORD_W'(1);
      row_in     = row_cur;
      rs_in      = rs_cur;
      if (last_in) begin
         col_in = '0;
         row_in = '0;
      end else if (row_end) begin
         col_in = '0;
         row_in = row_cur + COORD_W'(1);
         rs_in  = rs_cur + stride_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         rs_ff  <= '0;
      end else if (cmd.load) begin
         col_ff <= col_in;
         row_ff <= row_in;
         rs_ff  <= rs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_ff  <= req_src_pixel;
         dst_ff  <= req_dst_pixel;
         addr_ff <= addr_in;
         last_ff <= last_in;
      end
      if (cmd.scale) begin
         sc_ff <= div15(scale_prod);
      end
      if (cmd.mix) begin
         pix_ff <= pix_in;
      end
   end

   assign scale_prod = 8'(alpha_ff) * 8'(src_ff[3:0]);
   assign sc_inv     = NIBBLE_MAX - sc_ff;

   always_comb begin
      pix_in = fill_ff;
      for (int k = 0; k < 4; k++) begin
         sn[k]      = src_ff[4*k +: 4];
         dn[k]      = dst_ff[4*k +: 4];
         mix_sum[k] = 8'(sn[k]) * 8'(sc_ff) + 8'(dn[k]) * 8'(sc_inv);
      end
      if (mode_ff[MODE_BLEND_BIT]) begin
         for (int k = 0; k < 4; k++) begin
            pix_in[4*k +: 4] = div15(mix_sum[k]);
         end
      end else if (mode_ff == MODE_COPY) begin
         pix_in = src_ff;
      end
   end

   assign rsp_write_address = addr_ff;
   assign rsp_out_pixel     = pix_ff;
   assign rsp_last_pixel    = last_ff;

endmodule

// ===== design/rgba4444_blit_pixel_engine.sv =====
// Top level of the RGBA4444 blit pixel engine.
// Joins rgbablit_ctrl and rgbablit_dpath; uses rgbablit_pkg.
//
// Usage:
//   csr_*  : register writes (index, data), always ready; write only while idle.
//            0 mode, 1 blend alpha, 2 fill color, 3 dst base, 4 dst stride,
//            5 width in pixels, 6 row total.
//   req_*  : one item per destination pixel in row-major order: source pixel
//            and current destination pixel.
//   rsp_*  : write address, pixel to write and a last-pixel flag.
// Flow: an accepted item is loaded, alpha scaled and nibble mixed, each in its own
//   FSM state, before its result is sent. The FSM handles one item at a time
//   (accept, alpha scale, nibble mix, send) and takes no new item until the result is taken.
// With width zero, items are taken and dropped without a result.
// When rsp_ready is low the result holds and req_ready stays low until it is taken.
// Reset clears the registers (row total to one) and the walk position.
module rgba4444_blit_pixel_engine
   import rgbablit_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_src_pixel,
   input  logic [PIX_W-1:0]     req_dst_pixel,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ADDR_W-1:0]    rsp_write_address,
   output logic [PIX_W-1:0]     rsp_out_pixel,
   output logic                 rsp_last_pixel,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   rgbablit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rgbablit_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_src_pixel     (req_src_pixel),
      .req_dst_pixel     (req_dst_pixel),
      .rsp_write_address (rsp_write_address),
      .rsp_out_pixel     (rsp_out_pixel),
      .rsp_last_pixel    (rsp_last_pixel)
   );

endmodule

// ===== tb/tb_rgba4444_blit_pixel_engine.sv =====
`timescale 1ns / 1ps
// Testbench for rgba4444_blit_pixel_engine: fill, copy and blend rectangles, directed then random,
// with every write checked against an in-bench model of the rectangle walk and pixel mix.
// Depends on rgbablit_pkg and the engine RTL.
module tb_rgba4444_blit_pixel_engine;
   import rgbablit_pkg::*;

   localparam logic [1:0] MODE_BLEND     = 2'(1 << MODE_BLEND_BIT);
   localparam logic [1:0] MODE_BLEND_ODD = MODE_BLEND | MODE_COPY;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_WRITES = 1600;
   localparam int MAX_REPORTS   = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  pixel;
      logic              last;
   } pixel_write_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_src_pixel;
   logic [PIX_W-1:0]     req_dst_pixel;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [ADDR_W-1:0]    rsp_write_address;
   logic [PIX_W-1:0]     rsp_out_pixel;
   logic                 rsp_last_pixel;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   rgba4444_blit_pixel_engine dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_src_pixel     (req_src_pixel),
      .req_dst_pixel     (req_dst_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_address (rsp_write_address),
      .rsp_out_pixel     (rsp_out_pixel),
      .rsp_last_pixel    (rsp_last_pixel),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   logic [1:0]         cfg_mode;
   logic [3:0]         cfg_alpha;
   logic [PIX_W-1:0]   cfg_fill;
   logic [ADDR_W-1:0]  cfg_base;
   logic [15:0]        cfg_stride;
   logic [COORD_W-1:0] cfg_width;
   logic [COORD_W-1:0] cfg_rows;
   logic [COORD_W-1:0] walk_col;
   logic [COORD_W-1:0] walk_row;
   logic [ADDR_W-1:0]  walk_row_addr;

   pixel_write_type pending_writes[$];
   int           fault_count      = 0;
   int           writes_predicted = 0;
   int unsigned  hold_request     = 0;
   bit           req_gaps_on      = 1'b0;
   bit           rsp_gaps_on      = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [COORD_W-1:0] clamp_width();
      return (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_rows();
      if (cfg_rows == '0) return COORD_W'(1);
      return (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
   endfunction

   function automatic logic [PIX_W-1:0] blend_over(input logic [PIX_W-1:0] s, d,
                                                   input logic [3:0] ga);
      int unsigned nmax = 32'(NIBBLE_MAX);
      int unsigned gau, sc, sn, dn;
      logic [PIX_W-1:0] r;
      gau = 32'(ga);
      sn  = 32'(s[3:0]);
      sc  = (gau * sn) / nmax;
      for (int k = 0; k < 4; k++) begin
         sn = 32'(s[4*k +: 4]);
         dn = 32'(d[4*k +: 4]);
         r[4*k +: 4] = 4'((sn * sc + dn * (nmax - sc)) / nmax);
      end
      return r;
   endfunction

   function automatic void predict_pixel_write(input logic [PIX_W-1:0] s, d);
      logic [COORD_W-1:0] w, h;
      logic [ADDR_W-1:0]  stride32;
      pixel_write_type    wr;
      if (cfg_width == '0) return;
      w = clamp_width();
      h = clamp_rows();
      if (walk_col >= w || walk_row >= h) begin
         walk_col = '0;
         walk_row = '0;
      end
      if (walk_col == '0 && walk_row == '0) walk_row_addr = cfg_base;
      if (cfg_mode[MODE_BLEND_BIT]) wr.pixel = blend_over(s, d, cfg_alpha);
      else if (cfg_mode == MODE_COPY) wr.pixel = s;
      else wr.pixel = cfg_fill;
      wr.last = (walk_col == w - COORD_W'(1)) && (walk_row == h - COORD_W'(1));
      wr.addr = walk_row_addr + ADDR_W'({walk_col, 1'b0});
      stride32 = {{16{cfg_stride[15]}}, cfg_stride};
      if (wr.last) begin
         walk_col = '0;
         walk_row = '0;
      end else if (walk_col == w - COORD_W'(1)) begin
         walk_col = '0;
         walk_row++;
         walk_row_addr = walk_row_addr + stride32;
      end else begin
         walk_col++;
      end
      pending_writes.push_back(wr);
      writes_predicted++;
   endfunction

   function automatic void note_fault(input string what, input logic [ADDR_W-1:0] want, got);
      fault_count++;
      if (fault_count <= MAX_REPORTS)
         $display("%0t: %s: expected %h, got %h", $time, what, want, got);
   endfunction

   initial begin : check_writes
      pixel_write_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_writes.size() == 0) begin
               note_fault("write with none expected", '0, rsp_write_address);
            end else begin
               want = pending_writes.pop_front();
               if (rsp_write_address !== want.addr)
                  note_fault("write address", want.addr, rsp_write_address);
               if (rsp_out_pixel !== want.pixel)
                  note_fault("out pixel", ADDR_W'(want.pixel), ADDR_W'(rsp_out_pixel));
               if (rsp_last_pixel !== want.last)
                  note_fault("last pixel", ADDR_W'(want.last), ADDR_W'(rsp_last_pixel));
            end
         end
      end
   end

   initial begin : drive_rsp_ready
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request != 0) begin
            stall_left = hold_request - 1;
            hold_request = 0;
            rsp_ready <= 1'b0;
         end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DAT_W-1:0] value);
      int                   keep;
      logic [CSR_DAT_W-1:0] mask, data;
      case (idx)
         REG_MODE:        keep = 2;
         REG_BLEND_ALPHA: keep = 4;
         REG_FILL_COLOR:  keep = 16;
         REG_DST_BASE:    keep = 32;
         REG_DST_STRIDE:  keep = 16;
         default:         keep = COORD_W;
      endcase
      mask = (keep >= 32) ? '1 : ((32'd1 << keep) - 1);
      data = (value & mask) | ($urandom() & ~mask);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MODE:        cfg_mode   = data[1:0];
         REG_BLEND_ALPHA: cfg_alpha  = data[3:0];
         REG_FILL_COLOR:  cfg_fill   = data[15:0];
         REG_DST_BASE:    cfg_base   = data;
         REG_DST_STRIDE:  cfg_stride = data[15:0];
         REG_WIDTH:       cfg_width  = data[COORD_W-1:0];
         REG_ROW_TOTAL:   cfg_rows   = data[COORD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_rect(input logic [1:0] mode, input logic [3:0] alpha,
                           input logic [PIX_W-1:0] fill, input logic [ADDR_W-1:0] base,
                           input logic [15:0] stride, input logic [COORD_W-1:0] width, rows);
      write_reg(REG_MODE, CSR_DAT_W'(mode));
      write_reg(REG_BLEND_ALPHA, CSR_DAT_W'(alpha));
      write_reg(REG_FILL_COLOR, CSR_DAT_W'(fill));
      write_reg(REG_DST_BASE, base);
      write_reg(REG_DST_STRIDE, CSR_DAT_W'(stride));
      write_reg(REG_WIDTH, CSR_DAT_W'(width));
      write_reg(REG_ROW_TOTAL, CSR_DAT_W'(rows));
      csr_valid <= 1'b0;
   endtask

   task automatic push_pixel(input logic [PIX_W-1:0] s, d);
      int unsigned gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_src_pixel <= s;
      req_dst_pixel <= d;
      do @(posedge clock); while (!req_ready);
      predict_pixel_write(s, d);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_fill_extremes();
      settle();
      set_rect(MODE_FILL, 4'hf, 16'hffff, 32'hffff_fffc, 16'h8000, 13'd2, 13'd2);
      repeat (4) push_pixel($urandom(), $urandom());
      settle();
      set_rect(MODE_FILL, 4'h0, 16'h0000, 32'hffff_ffff, 16'h7fff, 13'd1, 13'd2);
      repeat (2) push_pixel(16'hffff, 16'hffff);
   endtask

   task automatic test_copy_extremes();
      settle();
      set_rect(MODE_COPY, 4'h0, 16'h1234, 32'h8000_0000, 16'hffff, 13'd2, 13'd2);
      push_pixel(16'h0000, 16'hffff);
      push_pixel(16'hffff, 16'h0000);
      push_pixel(16'ha5a5, 16'h5a5a);
      push_pixel(16'h5a5a, 16'ha5a5);
   endtask

   task automatic test_blend_weights();
      settle();
      set_rect(MODE_BLEND, 4'hf, 16'h0000, 32'h0000_1000, 16'd64, 13'd4, 13'd1);
      push_pixel(16'hffff, 16'h0000);
      push_pixel(16'hfff0, 16'hffff);
      push_pixel(16'h8887, 16'h1234);
      push_pixel(16'h0f0f, 16'hf0f0);
      settle();
      set_rect(MODE_BLEND, 4'h0, 16'hffff, 32'h0000_2000, 16'd0, 13'd1, 13'd1);
      push_pixel(16'hffff, 16'h0000);
   endtask

   task automatic test_mode_three();
      settle();
      set_rect(MODE_BLEND_ODD, 4'h9, 16'h0000, 32'h0000_0040, 16'd0, 13'd2, 13'd1);
      push_pixel(16'hc3a9, 16'h1e5b);
      push_pixel(16'h7f7f, 16'h8080);
   endtask

   task automatic test_zero_width();
      settle();
      set_rect(MODE_COPY, 4'h0, 16'h0000, 32'h0000_0200, 16'd8, 13'd0, 13'd1);
      repeat (3) push_pixel($urandom(), $urandom());
      settle();
      set_rect(MODE_COPY, 4'h0, 16'h0000, 32'h0000_0200, 16'd8, 13'd1, 13'd0);
      repeat (2) push_pixel($urandom(), $urandom());
   endtask

   task automatic test_clamp_and_restart();
      settle();
      set_rect(MODE_COPY, 4'h3, 16'hbeef, 32'hffff_f000, 16'h8000, 13'h1fff, 13'h1fff);
      repeat (3) push_pixel($urandom(), $urandom());
      settle();
      write_reg(REG_WIDTH, 32'd2);
      csr_valid <= 1'b0;
      repeat (3) push_pixel($urandom(), $urandom());
      settle();
      write_reg(REG_ROW_TOTAL, 32'd1);
      csr_valid <= 1'b0;
      push_pixel($urandom(), $urandom());
   endtask

   task automatic test_backpressure();
      settle();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      set_rect(MODE_BLEND, 4'hf, 16'h0000, 32'h0001_0000, 16'd640, 13'd5, 13'd4);
      hold_request = HOLD_CYCLES;
      repeat (20) push_pixel($urandom(), $urandom());
   endtask

   task automatic test_random_frames();
      int          start, count, full_size, r;
      bit          all_regs;
      start = writes_predicted;
      while (writes_predicted - start < RANDOM_WRITES) begin
         settle();
         req_gaps_on = ($urandom_range(0, 9) < 7);
         rsp_gaps_on = ($urandom_range(0, 9) < 7);
         all_regs = ($urandom_range(0, 3) == 0);
         if (all_regs || $urandom_range(0, 1)) write_reg(REG_MODE, $urandom_range(0, 3));
         if (all_regs || $urandom_range(0, 1)) begin
            r = $urandom_range(0, 3);
            write_reg(REG_BLEND_ALPHA, (r == 0) ? 0 : (r == 1) ? 15 : $urandom_range(0, 15));
         end
         if (all_regs || $urandom_range(0, 1)) write_reg(REG_FILL_COLOR, $urandom());
         if (all_regs || $urandom_range(0, 1)) begin
            r = $urandom_range(0, 5);
            write_reg(REG_DST_BASE, (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff :
                                    (r == 2) ? 32'hffff_fff0 : $urandom());
         end
         if (all_regs || $urandom_range(0, 1)) begin
            r = $urandom_range(0, 5);
            write_reg(REG_DST_STRIDE, (r == 0) ? 32'h8000 : (r == 1) ? 32'h7fff :
                                      (r == 2) ? 32'h0000 : $urandom_range(0, 16'hffff));
         end
         if (all_regs || $urandom_range(0, 1)) begin
            r = $urandom_range(0, 99);
            if (r < 4) write_reg(REG_WIDTH, 0);
            else if (r < 6) write_reg(REG_WIDTH, (r == 4) ? 32'h1fff : 32'd4097);
            else if (r < 7) write_reg(REG_WIDTH, 32'd4096);
            else if (r < 82) write_reg(REG_WIDTH, $urandom_range(1, 6));
            else write_reg(REG_WIDTH, $urandom_range(7, 24));
         end
         if (all_regs || $urandom_range(0, 1)) begin
            r = $urandom_range(0, 99);
            if (r < 8) write_reg(REG_ROW_TOTAL, 0);
            else if (r < 11) write_reg(REG_ROW_TOTAL, (r == 8) ? 32'h1fff : 32'd4096);
            else write_reg(REG_ROW_TOTAL, $urandom_range(1, 5));
         end
         csr_valid <= 1'b0;
         if (cfg_width == '0) begin
            count = $urandom_range(1, 6);
         end else begin
            full_size = int'(clamp_width()) * int'(clamp_rows());
            if ($urandom_range(0, 9) < 8 && full_size <= 150) count = full_size;
            else count = $urandom_range(1, 12);
         end
         repeat (count) push_pixel($urandom(), $urandom());
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_src_pixel <= '0;
      req_dst_pixel <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= REG_MODE;
      csr_data      <= '0;
      cfg_mode      = MODE_FILL;
      cfg_alpha     = '0;
      cfg_fill      = '0;
      cfg_base      = '0;
      cfg_stride    = '0;
      cfg_width     = '0;
      cfg_rows      = COORD_W'(1);
      walk_col      = '0;
      walk_row      = '0;
      walk_row_addr = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_extremes();
      test_copy_extremes();
      test_blend_weights();
      test_mode_three();
      test_zero_width();
      test_clamp_and_restart();
      test_backpressure();
      test_random_frames();
      settle();
      if (pending_writes.size() != 0) fault_count++;
      if (fault_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
